FILE: hdl/hrkm_pkg.sv
// Shared types, constants and the key position ROM for the HID to key matrix unit.
package hrkm_pkg;

  // Key slots per report and key fields carried on the input port
  localparam int KEY_SLOTS  = 6;
  localparam int KEY_FIELDS = 6;

  // Matrix geometry
  localparam int COLS      = 7;
  localparam int ROWS      = 8;
  localparam int CELLS     = COLS * ROWS;
  localparam int ROM_TOP   = 104;

  // Item kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PROBE  = 1'b1;

  // Special codes and masks
  localparam logic [7:0] CODE_SHIFT    = 8'h68;
  localparam logic [7:0] CODE_DELETE   = 8'h4C;
  localparam logic [7:0] NO_POS        = 8'hFF;
  localparam logic [7:0] SHIFT_MASK    = 8'h22;
  localparam logic [7:0] CTRL_ALT_MASK = 8'h05;
  localparam logic [6:0] COL_IDLE      = 7'h7F;

  typedef logic [KEY_SLOTS-1:0][7:0] key_list_t;
  typedef logic [COLS-1:0][ROWS-1:0] matrix_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] modifier_bits;
    key_list_t  keys;
    logic [6:0] column_lines;
  } item_t;

  typedef struct packed {
    logic [7:0] row_lines;
    logic       reset_line;
  } result_t;

  // Position per HID code: (column << 3) | row, or NO_POS
  localparam logic [7:0] POS_ROM [0:ROM_TOP] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04,
    8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C,
    8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
    8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h21, 8'h22,
    8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h20,
    8'h30, 8'h31, 8'h1D, 8'h1B, 8'h1F, 8'hFF, 8'h2D, 8'h1D,
    8'h1E, 8'hFF, 8'hFF, 8'h2A, 8'h2B, 8'hFF, 8'h2C, 8'h2E,
    8'h2F, 8'h1C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h33, 8'hFF, 8'hFF, 8'h1E,
    8'h1D, 8'h1C, 8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h30, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h20, 8'h2E, 8'hFF, 8'h34, 8'hFF, 8'h2D,
    8'h35
  };

  // One-hot matrix cell for a code, all zero for unmapped codes
  function automatic matrix_t key_mask(input logic [7:0] code);
    logic [7:0] pos;
    matrix_t    mask;
    pos  = NO_POS;
    mask = '0;
    if (code <= 8'(ROM_TOP)) pos = POS_ROM[code[6:0]];
    if (pos != NO_POS && pos[7:3] < 5'(COLS)) mask[pos[5:3]][pos[2:0]] = 1'b1;
    return mask;
  endfunction

endpackage

FILE: hdl/hrkm_in_stage.sv
// Input register stage: captures one request and holds it until the engine takes it.
module hrkm_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hrkm_pkg::item_t in_item,
  input  logic          advance,
  output logic          s1_valid,
  output hrkm_pkg::item_t s1_item
);
  import hrkm_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // Stall only while a held request cannot move on
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

FILE: hdl/hrkm_engine.sv
// Matrix state and the single-pass report/probe logic.
module hrkm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  hrkm_pkg::item_t   item,
  output hrkm_pkg::result_t result
);
  import hrkm_pkg::*;

  matrix_t   matrix_r, matrix_nxt;
  key_list_t last_keys_r;
  logic      shift_held_r;
  logic      reset_level_r, reset_level_nxt;

  logic      this_shift, ctrl_alt, is_report;
  matrix_t   rel_mask, press_mask;
  logic      del_gone, del_new;
  logic      in_cur, in_last;
  logic [7:0] rows;

  assign is_report  = (item.kind == KIND_REPORT);
  assign this_shift = (item.modifier_bits & SHIFT_MASK) != 8'h00;
  assign ctrl_alt   = (item.modifier_bits & CTRL_ALT_MASK) == CTRL_ALT_MASK;

  // Gather releases and presses; all releases precede all presses
  always_comb begin
    rel_mask   = '0;
    press_mask = '0;
    del_gone   = 1'b0;
    del_new    = 1'b0;
    if (shift_held_r && !this_shift) rel_mask = rel_mask | key_mask(CODE_SHIFT);
    if (!shift_held_r && this_shift) press_mask = press_mask | key_mask(CODE_SHIFT);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      in_cur  = 1'b0;
      in_last = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (item.keys[j] == last_keys_r[i]) in_cur = 1'b1;
        if (last_keys_r[j] == item.keys[i]) in_last = 1'b1;
      end
      // Vanished code
      if (last_keys_r[i] != 8'h00 && !in_cur) begin
        if (ctrl_alt && last_keys_r[i] == CODE_DELETE) begin
          del_gone = 1'b1;
        end else begin
          rel_mask = rel_mask | key_mask(last_keys_r[i]);
        end
      end
      // New code
      if (item.keys[i] != 8'h00 && !in_last) begin
        if (ctrl_alt && item.keys[i] == CODE_DELETE) begin
          del_new = 1'b1;
        end else begin
          press_mask = press_mask | key_mask(item.keys[i]);
        end
      end
    end
  end

  always_comb begin
    matrix_nxt = (matrix_r & ~rel_mask) | press_mask;
    reset_level_nxt = reset_level_r;
    if (del_new) begin
      reset_level_nxt = 1'b1;
    end else if (del_gone) begin
      reset_level_nxt = 1'b0;
    end
  end

  // Answer a probe with the row byte of the single low column line
  always_comb begin
    rows = 8'h00;
    for (int b = 0; b < COLS; b++) begin
      if (item.column_lines == (COL_IDLE ^ (7'(1) << b))) rows = matrix_r[COLS-1-b];
    end
  end

  always_comb begin
    if (is_report) begin
      result.row_lines  = 8'h00;
      result.reset_line = reset_level_nxt;
    end else begin
      result.row_lines  = rows;
      result.reset_line = reset_level_r;
    end
  end

  // Commit state when a report moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r      <= '0;
      last_keys_r   <= '0;
      shift_held_r  <= 1'b0;
      reset_level_r <= 1'b0;
    end else if (fire && is_report) begin
      matrix_r      <= matrix_nxt;
      last_keys_r   <= item.keys;
      shift_held_r  <= this_shift;
      reset_level_r <= reset_level_nxt;
    end
  end
endmodule

FILE: hdl/hrkm_out_stage.sv
// Result register: holds one result until downstream takes it.
module hrkm_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  hrkm_pkg::result_t s1_result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output hrkm_pkg::result_t out_result
);
  import hrkm_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  // Move on when the register is empty or being drained
  assign advance = s1_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= s1_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;
endmodule

FILE: hdl/hid_report_to_key_matrix_unit.sv
// Top level of the HID report to key matrix unit.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | in_valid/in_stall, kind, mods, keys a-f | in
//            | and column_lines                        |
//   result   | out_valid/out_stall, row_lines,         | out
//            | reset_line                              |
//
// One request per cycle while the result side is not stalled; a result
// passes through the input register, then the result register.
// All state (matrix, previous keys, shift flag, reset level) updates in the
// single cycle that moves a report into the result register.
// Synchronous reset clears the matrix, previous keys and the reset level.
// A stall on the result side holds the result; the input register still
// takes one more request before in_stall rises.
module hid_report_to_key_matrix_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_key_a,
  input  logic [7:0] in_key_b,
  input  logic [7:0] in_key_c,
  input  logic [7:0] in_key_d,
  input  logic [7:0] in_key_e,
  input  logic [7:0] in_key_f,
  input  logic [6:0] in_column_lines,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_row_lines,
  output logic       out_reset_line
);
  import hrkm_pkg::*;

  logic [KEY_FIELDS-1:0][7:0] fields;
  item_t   in_item, s1_item;
  result_t s1_result, out_result;
  logic    s1_valid, advance;

  // Pack the request; slots beyond the port fields read as empty
  assign fields = {in_key_f, in_key_e, in_key_d, in_key_c, in_key_b, in_key_a};

  always_comb begin
    in_item.kind          = in_kind;
    in_item.modifier_bits = in_modifier_bits;
    in_item.column_lines  = in_column_lines;
    in_item.keys          = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (i < KEY_FIELDS) in_item.keys[i] = fields[i];
    end
  end

  hrkm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  hrkm_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item),
    .result (s1_result)
  );

  hrkm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_result  (s1_result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_row_lines  = out_result.row_lines;
  assign out_reset_line = out_result.reset_line;
endmodule

FILE: hdl/hrkm_checker.sv
// Port-level assertions for the HID report to key matrix unit, with its bind.
module hrkm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_row_lines,
  input logic       out_reset_line
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_lines)
      && $stable(out_reset_line))
    else $error("stalled result changed");

  // Input only stalls when both registers are full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A result appears only for a request taken earlier, through the input register and then the result register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a request");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hid_report_to_key_matrix_unit hrkm_checker u_hrkm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_row_lines  (out_row_lines),
  .out_reset_line (out_reset_line)
);

FILE: dv/tb_hid_report_to_key_matrix_unit.sv
// Self-checking testbench for the HID report to key matrix unit.
`timescale 1ns / 1ps

module tb_hid_report_to_key_matrix_unit;
  import hrkm_pkg::*;

  localparam int         CYCLE_LIMIT = 200_000;
  localparam int         TAIL_CYCLES = 8;
  localparam int         HOLD_CYCLES = 400;
  localparam int         PRINT_CAP   = 40;
  localparam logic [7:0] LAST_CODE   = 8'h68;

  // Key position per HID code: column in bits 5:3, row in bits 2:0
  localparam logic [7:0] KEY_POS [0:104] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04,
    8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C,
    8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
    8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h21, 8'h22,
    8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h20,
    8'h30, 8'h31, 8'h1D, 8'h1B, 8'h1F, 8'hFF, 8'h2D, 8'h1D,
    8'h1E, 8'hFF, 8'hFF, 8'h2A, 8'h2B, 8'hFF, 8'h2C, 8'h2E,
    8'h2F, 8'h1C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h33, 8'hFF, 8'hFF, 8'h1E,
    8'h1D, 8'h1C, 8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h30, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h20, 8'h2E, 8'hFF, 8'h34, 8'hFF, 8'h2D,
    8'h35
  };

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic       in_kind          = KIND_REPORT;
  logic [7:0] in_modifier_bits = 8'h00;
  logic [7:0] in_key_a         = 8'h00;
  logic [7:0] in_key_b         = 8'h00;
  logic [7:0] in_key_c         = 8'h00;
  logic [7:0] in_key_d         = 8'h00;
  logic [7:0] in_key_e         = 8'h00;
  logic [7:0] in_key_f         = 8'h00;
  logic [6:0] in_column_lines  = COL_IDLE;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [7:0] out_row_lines;
  logic       out_reset_line;

  // Predicted matrix and report history
  logic [7:0] key_rows [0:COLS-1] = '{default: 8'h00};
  logic [7:0] prev_mods  = 8'h00;
  key_list_t  prev_keys  = '0;
  logic       reset_lvl  = 1'b0;

  // Replies still owed by the block, oldest first
  result_t    reply_q [$];

  // Typing session used to build plausible report sequences
  logic [7:0] typing_mods = 8'h00;
  key_list_t  typing_keys = '0;

  int         err_count   = 0;
  int         cycle_count = 0;
  int         hold_left   = 0;
  int         stall_left  = 0;
  bit         tx_idle_en  = 1'b1;
  bit         rx_idle_en  = 1'b1;

  hid_report_to_key_matrix_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_modifier_bits (in_modifier_bits),
    .in_key_a         (in_key_a),
    .in_key_b         (in_key_b),
    .in_key_c         (in_key_c),
    .in_key_d         (in_key_d),
    .in_key_e         (in_key_e),
    .in_key_f         (in_key_f),
    .in_column_lines  (in_column_lines),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_lines    (out_row_lines),
    .out_reset_line   (out_reset_line)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Press or release the matrix cell of one code; ignore unmapped codes
  function automatic void set_cell(input logic [7:0] code, input logic down);
    logic [7:0] p;
    p = NO_POS;
    if (code <= LAST_CODE) p = KEY_POS[code];
    if (p != NO_POS && p[7:3] < 5'(COLS)) key_rows[p[5:3]][p[2:0]] = down;
  endfunction

  function automatic logic holds_code(input key_list_t list, input logic [7:0] code);
    for (int i = 0; i < KEY_SLOTS; i++)
      if (list[i] == code) return 1'b1;
    return 1'b0;
  endfunction

  // Apply one request to the predicted state and return the reply it earns
  function automatic result_t apply_request(input item_t r);
    result_t    res;
    logic       was_shift;
    logic       now_shift;
    logic       ctrl_alt;
    logic [7:0] c;
    res = '0;
    if (r.kind == KIND_PROBE) begin
      for (int b = 0; b < COLS; b++)
        if (r.column_lines == (COL_IDLE ^ (7'd1 << b))) res.row_lines = key_rows[COLS-1-b];
      res.reset_line = reset_lvl;
      return res;
    end
    was_shift = (prev_mods & SHIFT_MASK) != 8'h00;
    now_shift = (r.modifier_bits & SHIFT_MASK) != 8'h00;
    ctrl_alt  = (r.modifier_bits & CTRL_ALT_MASK) == CTRL_ALT_MASK;
    // shift release, then vanished codes
    if (was_shift && !now_shift) set_cell(CODE_SHIFT, 1'b0);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      c = prev_keys[i];
      if (c != 8'h00 && !holds_code(r.keys, c)) begin
        if (ctrl_alt && c == CODE_DELETE) reset_lvl = 1'b0;
        else set_cell(c, 1'b0);
      end
    end
    // shift press, then new codes
    if (!was_shift && now_shift) set_cell(CODE_SHIFT, 1'b1);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      c = r.keys[i];
      if (c != 8'h00 && !holds_code(prev_keys, c)) begin
        if (ctrl_alt && c == CODE_DELETE) reset_lvl = 1'b1;
        else set_cell(c, 1'b1);
      end
    end
    prev_keys      = r.keys;
    prev_mods      = r.modifier_bits;
    res.reset_line = reset_lvl;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t ns",
               what, got, want, $time);
  endtask

  // Offer one request and hold it until accepted, then record its reply
  task automatic send_request(input item_t r);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_kind          <= r.kind;
    in_modifier_bits <= r.modifier_bits;
    in_key_a         <= r.keys[0];
    in_key_b         <= r.keys[1];
    in_key_c         <= r.keys[2];
    in_key_d         <= r.keys[3];
    in_key_e         <= r.keys[4];
    in_key_f         <= r.keys[5];
    in_column_lines  <= r.column_lines;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    reply_q.push_back(apply_request(r));
  endtask

  task automatic send_report(input logic [7:0] mods, input logic [7:0] a,
                             input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d, input logic [7:0] e,
                             input logic [7:0] f);
    item_t r;
    r               = '0;
    r.kind          = KIND_REPORT;
    r.modifier_bits = mods;
    r.keys          = {f, e, d, c, b, a};
    r.column_lines  = 7'($urandom);
    send_request(r);
  endtask

  task automatic send_probe(input logic [6:0] lines);
    item_t r;
    r               = '0;
    r.kind          = KIND_PROBE;
    r.modifier_bits = 8'($urandom);
    r.column_lines  = lines;
    send_request(r);
  endtask

  // Mostly probes and typing-like reports, with some fully random reports
  task automatic make_random_request(output item_t r);
    int         sel;
    int         slot;
    int         other;
    logic [7:0] tmp;
    r.kind          = KIND_REPORT;
    r.modifier_bits = 8'($urandom);
    for (int i = 0; i < KEY_SLOTS; i++) r.keys[i] = 8'($urandom);
    r.column_lines  = 7'($urandom);
    sel  = $urandom_range(0, 99);
    slot = $urandom_range(0, KEY_SLOTS - 1);
    if (sel < 35) begin
      r.kind = KIND_PROBE;
      if ($urandom_range(0, 4) != 0) r.column_lines = COL_IDLE ^ (7'd1 << $urandom_range(0, 6));
    end else if (sel < 88) begin
      // advance the typing session by one step
      case ($urandom_range(0, 9))
        0, 1, 2: typing_keys[slot] = 8'h00;
        3: typing_mods = typing_mods ^ (8'd1 << $urandom_range(0, 7));
        4: begin
          typing_mods       = typing_mods | CTRL_ALT_MASK;
          typing_keys[slot] = CODE_DELETE;
        end
        5: begin
          other              = $urandom_range(0, KEY_SLOTS - 1);
          tmp                = typing_keys[slot];
          typing_keys[slot]  = typing_keys[other];
          typing_keys[other] = tmp;
        end
        6: typing_keys[slot] = 8'($urandom);
        default: typing_keys[slot] = 8'($urandom_range(1, LAST_CODE));
      endcase
      r.modifier_bits = typing_mods;
      r.keys          = typing_keys;
    end
  endtask

  task automatic send_random(input int count);
    item_t r;
    repeat (count) begin
      make_random_request(r);
      send_request(r);
    end
  endtask

  // Letters, shift, unmapped and top codes, repeats and every single-column scan pattern
  task automatic test_key_codes;
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_probe(COL_IDLE);
    send_report(8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    for (int b = 0; b < COLS; b++) send_probe(COL_IDLE ^ (7'd1 << b));
    send_report(8'h20, 8'hFF, 8'h69, 8'h68, 8'h00, 8'h3A, 8'h49);
    send_probe(7'h7E);
    send_report(8'h00, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h1E);
    send_probe(7'h00);
    send_probe(7'h7C);
  endtask

  // Delete under Ctrl and Alt drives the reset line and leaves the matrix
  task automatic test_ctrl_alt_delete;
    send_report(CTRL_ALT_MASK, CODE_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_probe(7'h7E);
    send_report(CTRL_ALT_MASK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(8'h00, CODE_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(CTRL_ALT_MASK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_probe(7'h7E);
    send_report(8'hFF, CODE_DELETE, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_probe(7'h7E);
  endtask

  // Random traffic in segments, with idling switched per side
  task automatic test_random_traffic;
    for (int seg = 0; seg < 12; seg++) begin
      tx_idle_en = (seg % 3) != 0;
      rx_idle_en = (seg % 4) != 1;
      send_random(100);
    end
  endtask

  // Hold off the result side while requests keep coming
  task automatic test_backpressure;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_left  = HOLD_CYCLES;
    send_random(30);
  endtask

  // Finish with back-to-back traffic and no idling
  task automatic test_steady_tail;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(100);
  endtask

  // Drive the result stall: long hold first, then random bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expected reply
  always @(posedge clk) begin : chk_results
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected result", out_row_lines, 8'h00);
      end else begin
        want = reply_q.pop_front();
        if (out_row_lines !== want.row_lines)
          report_mismatch("row_lines", out_row_lines, want.row_lines);
        if (out_reset_line !== want.reset_line)
          report_mismatch("reset_line", 8'(out_reset_line), 8'(want.reset_line));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[hid_report_to_key_matrix_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_key_codes();
    test_ctrl_alt_delete();
    test_random_traffic();
    test_backpressure();
    test_steady_tail();
    in_valid <= 1'b0;
    // drain outstanding replies, then watch for stray results
    while (reply_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[hid_report_to_key_matrix_unit] OK");
    end else begin
      $display("[hid_report_to_key_matrix_unit] ERROR");
    end
    $finish;
  end

endmodule
